// ----- src/coap_header_option_parser_unit_macros.svh -----
// Assertion macros shared by the parser modules
`ifndef COAP_HEADER_OPTION_PARSER_UNIT_MACROS_SVH
`define COAP_HEADER_OPTION_PARSER_UNIT_MACROS_SVH

// condition must never hold at a clock edge outside reset
`define COHP_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define COHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cohp_pkg.sv -----
// Shared types and constants of the CoAP header and option parser
`default_nettype none

package cohp_pkg;

    localparam int DEF_MAX_OPTIONS       = 16;
    localparam int DEF_MAX_MESSAGE_BYTES = 256;
    localparam int DEF_QUEUE_DEPTH       = 2;

    localparam int OFF_W = 8;

    localparam logic [3:0] CFG_TOKEN_RESET = 4'd8;
    localparam logic [1:0] HDR_VER_ONE     = 2'd1;
    localparam logic [7:0] PAYLOAD_MARKER  = 8'hff;
    localparam logic [3:0] NIB_EXT1        = 4'd13;
    localparam logic [3:0] NIB_EXT2        = 4'd14;
    localparam logic [3:0] NIB_BAD         = 4'd15;

    typedef enum logic [3:0] {
        PH_H0      = 4'd0,
        PH_H1      = 4'd1,
        PH_H2      = 4'd2,
        PH_H3      = 4'd3,
        PH_TOKEN   = 4'd4,
        PH_OPT     = 4'd5,
        PH_DEXT    = 4'd6,
        PH_LEXT    = 4'd7,
        PH_VALUE   = 4'd8,
        PH_PAYLOAD = 4'd9,
        PH_DRAIN   = 4'd10
    } t_phase;

    typedef enum logic [2:0] {
        EV_HEADER    = 3'd0,
        EV_OPTION    = 3'd1,
        EV_PAYLOAD   = 3'd2,
        EV_REJECT    = 3'd3,
        EV_MALFORMED = 3'd4,
        EV_END       = 3'd5
    } t_event;

    // classified datagram byte as it travels from front to back
    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic [OFF_W-1:0] pos;
        logic [OFF_W-1:0] pos_next;
        logic             is_marker;
        logic             bad_nibble;
        logic [3:0]       dn;
        logic [3:0]       ln;
    } t_item;

endpackage

`default_nettype wire

// ----- src/coap_header_option_parser_unit.sv -----
// CoAP header and option parser: top level with configuration register
//
// Usage:
//   msg channel (i_msg_valid / o_msg_stall): one datagram byte per request,
//   i_msg_last on the final byte. Each byte is accepted at a rising edge with
//   valid high and stall low.
//   evt channel (o_evt_valid / i_evt_stall): at most one result per byte,
//   taken at an edge with valid high and stall low.
//   cfg channel (i_cfg_valid / o_cfg_ready): writes max_token_len; ready is
//   always high. Write only while no datagram bytes are in flight.
// Each accepted byte is written into the byte queue; the back end parses it
// from the queue head and loads any result into the result register.
// Throughput: one byte per cycle while the byte queue is not full.
// Bytes that cause no result pass the back end even while a result waits.
// When the receiver stalls, the result holds and the byte queue fills;
// o_msg_stall rises once the queue is full.
// Reset (synchronous, i_rst_n low) empties the queue, drops any pending result,
// restarts at header byte zero and sets max_token_len to 8.
`default_nettype none

module coap_header_option_parser_unit #(
    parameter int MAX_OPTIONS       = cohp_pkg::DEF_MAX_OPTIONS,
    parameter int MAX_MESSAGE_BYTES = cohp_pkg::DEF_MAX_MESSAGE_BYTES,
    parameter int QUEUE_DEPTH       = cohp_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_msg_valid,
    output logic             o_msg_stall,
    input  wire logic [7:0]  i_msg_byte,
    input  wire logic        i_msg_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_data,
    output logic             o_evt_valid,
    input  wire logic        i_evt_stall,
    output logic [2:0]       o_event_kind,
    output logic [1:0]       o_hdr_version,
    output logic [1:0]       o_hdr_type,
    output logic [3:0]       o_hdr_token_len,
    output logic [7:0]       o_hdr_code,
    output logic [15:0]      o_hdr_message_id,
    output logic [7:0]       o_option_number,
    output logic [8:0]       o_option_length,
    output logic [7:0]       o_value_offset,
    output logic             o_end_of_message
);

    logic [3:0]      r_max_tkl;
    logic            w_push;
    logic            w_full;
    logic            w_pop;
    logic            w_q_valid;
    cohp_pkg::t_item w_push_item;
    cohp_pkg::t_item w_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tkl <= cohp_pkg::CFG_TOKEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_tkl <= i_cfg_data;
        end
    end

    cohp_front #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_msg_valid(i_msg_valid),
        .o_msg_stall(o_msg_stall),
        .i_msg_byte (i_msg_byte),
        .i_msg_last (i_msg_last),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    cohp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_item (w_push_item),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_valid(w_q_valid),
        .o_head (w_head)
    );

    cohp_back #(
        .MAX_OPTIONS(MAX_OPTIONS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_item        (w_head),
        .o_pop           (w_pop),
        .i_max_token_len (r_max_tkl),
        .o_evt_valid     (o_evt_valid),
        .i_evt_stall     (i_evt_stall),
        .o_event_kind    (o_event_kind),
        .o_hdr_version   (o_hdr_version),
        .o_hdr_type      (o_hdr_type),
        .o_hdr_token_len (o_hdr_token_len),
        .o_hdr_code      (o_hdr_code),
        .o_hdr_message_id(o_hdr_message_id),
        .o_option_number (o_option_number),
        .o_option_length (o_option_length),
        .o_value_offset  (o_value_offset),
        .o_end_of_message(o_end_of_message)
    );

endmodule

`default_nettype wire

// ----- src/cohp_front.sv -----
// Front end: accepts datagram bytes, tracks byte position and classifies nibbles
`default_nettype none

module cohp_front #(
    parameter int MAX_MESSAGE_BYTES = cohp_pkg::DEF_MAX_MESSAGE_BYTES
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_msg_valid,
    output logic                o_msg_stall,
    input  wire logic [7:0]     i_msg_byte,
    input  wire logic           i_msg_last,
    input  wire logic           i_full,
    output logic                o_push,
    output cohp_pkg::t_item     o_item
);

`include "coap_header_option_parser_unit_macros.svh"

    localparam logic [cohp_pkg::OFF_W-1:0] POS_CAP =
        cohp_pkg::OFF_W'(MAX_MESSAGE_BYTES - 1);

    logic [cohp_pkg::OFF_W-1:0] r_pos;
    logic [cohp_pkg::OFF_W-1:0] n_pos;
    logic [cohp_pkg::OFF_W-1:0] w_pos_next;
    logic                       w_accept;

    assign o_msg_stall = i_full;
    assign w_accept    = i_msg_valid && !i_full;
    assign o_push      = w_accept;

    assign w_pos_next = (r_pos == POS_CAP) ? POS_CAP : r_pos + 1'b1;

    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            n_pos = i_msg_last ? '0 : w_pos_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_comb begin
        o_item.data       = i_msg_byte;
        o_item.last       = i_msg_last;
        o_item.pos        = r_pos;
        o_item.pos_next   = w_pos_next;
        o_item.is_marker  = (i_msg_byte == cohp_pkg::PAYLOAD_MARKER);
        o_item.dn         = i_msg_byte[7:4];
        o_item.ln         = i_msg_byte[3:0];
        o_item.bad_nibble = (i_msg_byte[7:4] == cohp_pkg::NIB_BAD) ||
                            (i_msg_byte[3:0] == cohp_pkg::NIB_BAD);
    end

    `COHP_ASSERT_NEVER(a_pos_cap, r_pos > POS_CAP, "byte position beyond cap")

endmodule

`default_nettype wire

// ----- src/cohp_queue.sv -----
// Short request queue between front end and parser back end
`default_nettype none

module cohp_queue #(
    parameter int DEPTH = cohp_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire cohp_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output cohp_pkg::t_item      o_head
);

`include "coap_header_option_parser_unit_macros.svh"

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cohp_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr;
    logic [PW-1:0]   n_rd;
    logic [CW-1:0]   n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `COHP_ASSERT_NEVER(a_no_overflow, i_push && o_full && !i_pop, "push into full queue")
    `COHP_ASSERT_NEVER(a_no_underflow, i_pop && !o_valid, "pop from empty queue")

endmodule

`default_nettype wire

// ----- src/cohp_back.sv -----
// Back end: header and option state machine with the result register
`default_nettype none

module cohp_back #(
    parameter int MAX_OPTIONS = cohp_pkg::DEF_MAX_OPTIONS
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire cohp_pkg::t_item i_q_item,
    output logic                 o_pop,
    input  wire logic [3:0]      i_max_token_len,
    output logic                 o_evt_valid,
    input  wire logic            i_evt_stall,
    output logic [2:0]           o_event_kind,
    output logic [1:0]           o_hdr_version,
    output logic [1:0]           o_hdr_type,
    output logic [3:0]           o_hdr_token_len,
    output logic [7:0]           o_hdr_code,
    output logic [15:0]          o_hdr_message_id,
    output logic [7:0]           o_option_number,
    output logic [8:0]           o_option_length,
    output logic [7:0]           o_value_offset,
    output logic                 o_end_of_message
);

`include "coap_header_option_parser_unit_macros.svh"

    localparam int OW = $clog2(MAX_OPTIONS + 1);
    localparam logic [OW-1:0] OPT_LIMIT = OW'(MAX_OPTIONS);

    cohp_pkg::t_phase r_phase, n_phase, w_step;
    logic [31:0] r_hdr, n_hdr, w_hdr;
    logic [7:0]  r_run, n_run;
    logic [3:0]  r_pdn, n_pdn;
    logic [3:0]  r_pln, n_pln;
    logic [8:0]  r_plen, n_plen;
    logic [8:0]  r_skip, n_skip;
    logic [OW-1:0] r_opts, n_opts;

    cohp_pkg::t_event w_kind;
    logic        w_ev;
    logic        w_fin;
    logic [7:0]  w_num;
    logic [8:0]  w_len;
    logic [7:0]  w_off;
    logic        w_pop;
    logic        w_load;

    logic        w_reject;
    logic        w_opt_full;
    logic [3:0]  w_tkl;
    logic [7:0]  w_b;
    logic [8:0]  w_ext_len;
    logic        w_skip_one;

    cohp_pkg::t_event r_kind;
    logic        r_evt_valid;
    logic [31:0] r_ohdr;
    logic [7:0]  r_num;
    logic [8:0]  r_len;
    logic [7:0]  r_off;
    logic        r_eom;

    assign w_b        = i_q_item.data;
    assign w_tkl      = r_hdr[27:24];
    assign w_reject   = (r_hdr[31:30] != cohp_pkg::HDR_VER_ONE) ||
                        (w_tkl > i_max_token_len);
    assign w_opt_full = (r_opts >= OPT_LIMIT);
    assign w_ext_len  = {1'b0, w_b} + 9'd13;
    assign w_skip_one = (r_skip == 9'd1);

    // next phase
    always_comb begin
        w_step = r_phase;
        unique case (r_phase)
            cohp_pkg::PH_H0: w_step = cohp_pkg::PH_H1;
            cohp_pkg::PH_H1: w_step = cohp_pkg::PH_H2;
            cohp_pkg::PH_H2: w_step = cohp_pkg::PH_H3;
            cohp_pkg::PH_H3: begin
                if (w_reject) begin
                    w_step = cohp_pkg::PH_DRAIN;
                end else if (w_tkl != '0) begin
                    w_step = cohp_pkg::PH_TOKEN;
                end else begin
                    w_step = cohp_pkg::PH_OPT;
                end
            end
            cohp_pkg::PH_TOKEN, cohp_pkg::PH_VALUE: begin
                if (w_skip_one) begin
                    w_step = cohp_pkg::PH_OPT;
                end
            end
            cohp_pkg::PH_OPT: begin
                if (w_opt_full || i_q_item.is_marker) begin
                    w_step = cohp_pkg::PH_PAYLOAD;
                end else if (i_q_item.bad_nibble) begin
                    w_step = cohp_pkg::PH_DRAIN;
                end else if (i_q_item.dn < cohp_pkg::NIB_EXT1) begin
                    if (i_q_item.ln < cohp_pkg::NIB_EXT1) begin
                        w_step = (i_q_item.ln != '0) ? cohp_pkg::PH_VALUE : cohp_pkg::PH_OPT;
                    end else begin
                        w_step = cohp_pkg::PH_LEXT;
                    end
                end else begin
                    w_step = cohp_pkg::PH_DEXT;
                end
            end
            cohp_pkg::PH_DEXT: begin
                if (w_skip_one) begin
                    if (r_pln < cohp_pkg::NIB_EXT1) begin
                        w_step = (r_pln != '0) ? cohp_pkg::PH_VALUE : cohp_pkg::PH_OPT;
                    end else begin
                        w_step = cohp_pkg::PH_LEXT;
                    end
                end
            end
            cohp_pkg::PH_LEXT: begin
                if (w_skip_one) begin
                    if (r_pln == cohp_pkg::NIB_EXT1) begin
                        w_step = cohp_pkg::PH_VALUE;
                    end else begin
                        w_step = (r_plen != '0) ? cohp_pkg::PH_VALUE : cohp_pkg::PH_OPT;
                    end
                end
            end
            cohp_pkg::PH_PAYLOAD, cohp_pkg::PH_DRAIN: w_step = r_phase;
            default: w_step = cohp_pkg::PH_DRAIN;
        endcase
        n_phase = i_q_item.last ? cohp_pkg::PH_H0 : w_step;
    end

    // events and datapath
    always_comb begin
        w_hdr  = r_hdr;
        n_run  = r_run;
        n_pdn  = r_pdn;
        n_pln  = r_pln;
        n_plen = r_plen;
        n_skip = r_skip;
        n_opts = r_opts;
        w_ev   = 1'b0;
        w_fin  = 1'b0;
        w_kind = cohp_pkg::EV_HEADER;
        w_num  = '0;
        w_len  = '0;
        w_off  = '0;
        unique case (r_phase)
            cohp_pkg::PH_H0: w_hdr = {w_b, 24'd0};
            cohp_pkg::PH_H1: w_hdr[23:16] = w_b;
            cohp_pkg::PH_H2: w_hdr[15:8] = w_b;
            cohp_pkg::PH_H3: begin
                w_hdr[7:0] = w_b;
                w_ev       = 1'b1;
                if (w_reject) begin
                    w_kind = cohp_pkg::EV_REJECT;
                end else begin
                    w_kind = cohp_pkg::EV_HEADER;
                    n_skip = {5'd0, w_tkl};
                end
            end
            cohp_pkg::PH_TOKEN, cohp_pkg::PH_VALUE: n_skip = r_skip - 1'b1;
            cohp_pkg::PH_OPT: begin
                if (w_opt_full) begin
                    w_ev   = 1'b1;
                    w_kind = cohp_pkg::EV_PAYLOAD;
                    w_off  = i_q_item.pos;
                end else if (i_q_item.is_marker) begin
                    w_ev   = 1'b1;
                    w_kind = cohp_pkg::EV_PAYLOAD;
                    w_off  = i_q_item.pos_next;
                end else begin
                    n_pdn = i_q_item.dn;
                    n_pln = i_q_item.ln;
                    if (i_q_item.bad_nibble) begin
                        w_ev   = 1'b1;
                        w_kind = cohp_pkg::EV_MALFORMED;
                    end else if (i_q_item.dn < cohp_pkg::NIB_EXT1) begin
                        n_run = r_run + {4'd0, i_q_item.dn};
                        if (i_q_item.ln < cohp_pkg::NIB_EXT1) begin
                            n_plen = {5'd0, i_q_item.ln};
                            w_fin  = 1'b1;
                        end else begin
                            n_plen = '0;
                            n_skip = (i_q_item.ln == cohp_pkg::NIB_EXT1) ? 9'd1 : 9'd2;
                        end
                    end else begin
                        if (i_q_item.dn == cohp_pkg::NIB_EXT2) begin
                            n_run = '0;
                        end
                        n_skip = (i_q_item.dn == cohp_pkg::NIB_EXT1) ? 9'd1 : 9'd2;
                    end
                end
            end
            cohp_pkg::PH_DEXT: begin
                if (r_pdn == cohp_pkg::NIB_EXT1) begin
                    n_run = r_run + 8'd13 + w_b;
                end
                n_skip = r_skip - 1'b1;
                if (w_skip_one) begin
                    if (r_pln < cohp_pkg::NIB_EXT1) begin
                        n_plen = {5'd0, r_pln};
                        w_fin  = 1'b1;
                    end else begin
                        n_plen = '0;
                        n_skip = (r_pln == cohp_pkg::NIB_EXT1) ? 9'd1 : 9'd2;
                    end
                end
            end
            cohp_pkg::PH_LEXT: begin
                if (r_pln == cohp_pkg::NIB_EXT1) begin
                    n_plen = w_ext_len;
                end
                n_skip = r_skip - 1'b1;
                if (w_skip_one) begin
                    w_fin = 1'b1;
                end
            end
            default: ;
        endcase

        if (w_fin) begin
            w_ev   = 1'b1;
            w_kind = cohp_pkg::EV_OPTION;
            w_num  = n_run;
            w_len  = n_plen;
            w_off  = i_q_item.pos_next;
            n_opts = r_opts + 1'b1;
            if (n_plen != '0) begin
                n_skip = n_plen;
            end
        end

        n_hdr = w_hdr;
        if (i_q_item.last) begin
            if (!w_ev) begin
                if (w_step == cohp_pkg::PH_H0 || w_step == cohp_pkg::PH_H1 ||
                    w_step == cohp_pkg::PH_H2 || w_step == cohp_pkg::PH_H3) begin
                    w_ev   = 1'b1;
                    w_kind = cohp_pkg::EV_REJECT;
                end else if (w_step == cohp_pkg::PH_DEXT || w_step == cohp_pkg::PH_LEXT) begin
                    w_ev   = 1'b1;
                    w_kind = cohp_pkg::EV_MALFORMED;
                end else if (w_step == cohp_pkg::PH_TOKEN || w_step == cohp_pkg::PH_OPT ||
                             w_step == cohp_pkg::PH_VALUE) begin
                    w_ev   = 1'b1;
                    w_kind = cohp_pkg::EV_END;
                end
            end
            n_hdr  = '0;
            n_run  = '0;
            n_pdn  = '0;
            n_pln  = '0;
            n_plen = '0;
            n_skip = '0;
            n_opts = '0;
        end
    end

    assign w_pop  = i_q_valid && (!w_ev || !r_evt_valid || !i_evt_stall);
    assign w_load = w_pop && w_ev;
    assign o_pop  = w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cohp_pkg::PH_H0;
            r_hdr   <= '0;
            r_run   <= '0;
            r_pdn   <= '0;
            r_pln   <= '0;
            r_plen  <= '0;
            r_skip  <= '0;
            r_opts  <= '0;
        end else if (w_pop) begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_run   <= n_run;
            r_pdn   <= n_pdn;
            r_pln   <= n_pln;
            r_plen  <= n_plen;
            r_skip  <= n_skip;
            r_opts  <= n_opts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evt_valid <= 1'b0;
        end else if (w_load) begin
            r_evt_valid <= 1'b1;
        end else if (!i_evt_stall) begin
            r_evt_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind <= w_kind;
            r_ohdr <= w_hdr;
            r_num  <= w_num;
            r_len  <= w_len;
            r_off  <= w_off;
            r_eom  <= i_q_item.last;
        end
    end

    assign o_evt_valid      = r_evt_valid;
    assign o_event_kind     = r_kind;
    assign o_hdr_version    = r_ohdr[31:30];
    assign o_hdr_type       = r_ohdr[29:28];
    assign o_hdr_token_len  = r_ohdr[27:24];
    assign o_hdr_code       = r_ohdr[23:16];
    assign o_hdr_message_id = r_ohdr[15:0];
    assign o_option_number  = r_num;
    assign o_option_length  = r_len;
    assign o_value_offset   = r_off;
    assign o_end_of_message = r_eom;

    `COHP_ASSERT_NEVER(a_opt_limit, w_load && w_kind == cohp_pkg::EV_OPTION && w_opt_full, "option past limit")
    `COHP_ASSERT_NEXT(a_last_rewinds, w_pop && i_q_item.last, r_phase == cohp_pkg::PH_H0 && r_opts == '0, "no rewind after last byte")
    `COHP_ASSERT_NEVER(a_quiet_tail, w_pop && !i_q_item.last && (r_phase == cohp_pkg::PH_PAYLOAD || r_phase == cohp_pkg::PH_DRAIN) && w_ev, "event inside payload or drain")

endmodule

`default_nettype wire
